/* rtl/ohlcv_pkg.sv */
// ohlcv_pkg: shared constants for the ohlcv bar aggregator
// widths of the interval register and the bucket span, seconds per minute
// no dependencies
package ohlcv_pkg;

    localparam int INTERVAL_BITS = 14;
    localparam int SECS_PER_MIN = 60;
    // interval * 60 fits in interval bits plus six
    localparam int SPAN_BITS = INTERVAL_BITS + 6;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(1);

endpackage

/* rtl/ohlcv_bar_aggregator_core.sv */
// ohlcv_bar_aggregator_core: resamples one-minute candles into bars of a set length
// bucket start found by a shared bit-serial remainder unit under a small sequencer
// depends on ohlcv_pkg
//
// A candle word is taken when in_valid and in_ready are high; in_ready is high only
// while the sequencer is idle. With an interval of one minute (or zero) candles pass
// through unchanged, emitting any open bar first, and wait on output back-pressure.
// With a longer interval the bucket start is the timestamp minus its remainder modulo
// interval*60, worked out by a restoring remainder unit one timestamp bit per cycle;
// each bar word emitted waits while out_ready is low.
// Each candle gives zero, one or two bar words; the candle flagged last_candle closes
// the open bar with final_bar set and clears the block for the next history. The user
// must write the interval through cfg_we/cfg_data only while the block is idle; the
// block does not enforce this. Volume sums saturate at all ones.
module ohlcv_bar_aggregator_core #(
    parameter int TIME_BITS = 40,
    parameter int VALUE_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ohlcv_pkg::INTERVAL_BITS-1:0] cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [TIME_BITS-1:0]                candle_timestamp,
    input  logic [VALUE_BITS-1:0]               candle_open,
    input  logic [VALUE_BITS-1:0]               candle_high,
    input  logic [VALUE_BITS-1:0]               candle_low,
    input  logic [VALUE_BITS-1:0]               candle_close,
    input  logic [VALUE_BITS-1:0]               candle_volume,
    input  logic                                last_candle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [TIME_BITS-1:0]                bar_timestamp,
    output logic [VALUE_BITS-1:0]               bar_open,
    output logic [VALUE_BITS-1:0]               bar_high,
    output logic [VALUE_BITS-1:0]               bar_low,
    output logic [VALUE_BITS-1:0]               bar_close,
    output logic [VALUE_BITS-1:0]               bar_volume,
    output logic                                final_bar
);
    import ohlcv_pkg::*;

    localparam int CNT_BITS = $clog2(TIME_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BUCKET,
        ST_DECIDE,
        ST_EMIT_OLD,
        ST_EMIT_PASS,
        ST_EMIT_FINAL
    } state_t;

    state_t                  state_reg, state_next;

    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic [SPAN_BITS-1:0]     span_reg, span_next;

    logic [TIME_BITS-1:0]     cts_reg, cts_next;
    logic [VALUE_BITS-1:0]    co_reg, co_next;
    logic [VALUE_BITS-1:0]    ch_reg, ch_next;
    logic [VALUE_BITS-1:0]    cl_reg, cl_next;
    logic [VALUE_BITS-1:0]    cc_reg, cc_next;
    logic [VALUE_BITS-1:0]    cv_reg, cv_next;
    logic                     clast_reg, clast_next;

    logic [TIME_BITS-1:0]     shift_reg, shift_next;
    logic [SPAN_BITS-1:0]     rem_reg, rem_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]     bucket_reg, bucket_next;

    logic                     bar_open_reg, bar_open_next;
    logic [TIME_BITS-1:0]     bucket_start_reg, bucket_start_next;
    logic [VALUE_BITS-1:0]    acc_open_reg, acc_open_next;
    logic [VALUE_BITS-1:0]    acc_high_reg, acc_high_next;
    logic [VALUE_BITS-1:0]    acc_low_reg, acc_low_next;
    logic [VALUE_BITS-1:0]    acc_close_reg, acc_close_next;
    logic [VALUE_BITS-1:0]    acc_volume_reg, acc_volume_next;

    logic                     out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]     out_ts_reg, out_ts_next;
    logic [VALUE_BITS-1:0]    out_open_reg, out_open_next;
    logic [VALUE_BITS-1:0]    out_high_reg, out_high_next;
    logic [VALUE_BITS-1:0]    out_low_reg, out_low_next;
    logic [VALUE_BITS-1:0]    out_close_reg, out_close_next;
    logic [VALUE_BITS-1:0]    out_volume_reg, out_volume_next;
    logic                     out_final_reg, out_final_next;

    logic                     pass_mode;
    logic                     out_free;
    logic [SPAN_BITS:0]       trial;
    logic [SPAN_BITS:0]       trial_sub;
    logic [VALUE_BITS:0]      vol_sum;
    logic [VALUE_BITS-1:0]    vol_sat;

    assign pass_mode = (interval_reg <= INTERVAL_BITS'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // remainder step: shift in the next timestamp bit, subtract span if it fits
    assign trial     = {rem_reg, shift_reg[TIME_BITS-1]};
    assign trial_sub = trial - {1'b0, span_reg};

    assign vol_sum = {1'b0, acc_volume_reg} + {1'b0, cv_reg};
    assign vol_sat = vol_sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : vol_sum[VALUE_BITS-1:0];

    always_comb
    begin
        state_next        = state_reg;
        interval_next     = interval_reg;
        span_next         = span_reg;
        cts_next          = cts_reg;
        co_next           = co_reg;
        ch_next           = ch_reg;
        cl_next           = cl_reg;
        cc_next           = cc_reg;
        cv_next           = cv_reg;
        clast_next        = clast_reg;
        shift_next        = shift_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        bucket_next       = bucket_reg;
        bar_open_next     = bar_open_reg;
        bucket_start_next = bucket_start_reg;
        acc_open_next     = acc_open_reg;
        acc_high_next     = acc_high_reg;
        acc_low_next      = acc_low_reg;
        acc_close_next    = acc_close_reg;
        acc_volume_next   = acc_volume_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_ts_next       = out_ts_reg;
        out_open_next     = out_open_reg;
        out_high_next     = out_high_reg;
        out_low_next      = out_low_reg;
        out_close_next    = out_close_reg;
        out_volume_next   = out_volume_reg;
        out_final_next    = out_final_reg;

        if (cfg_we)
        begin
            interval_next = cfg_data;
            // interval * 60 as interval * 64 - interval * 4
            span_next = {cfg_data, 6'b0} - {4'b0, cfg_data, 2'b0};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cts_next   = candle_timestamp;
                    co_next    = candle_open;
                    ch_next    = candle_high;
                    cl_next    = candle_low;
                    cc_next    = candle_close;
                    cv_next    = candle_volume;
                    clast_next = last_candle;
                    shift_next = candle_timestamp;
                    rem_next   = '0;
                    cnt_next   = CNT_BITS'(TIME_BITS - 1);
                    if (pass_mode)
                        state_next = bar_open_reg ? ST_EMIT_OLD : ST_EMIT_PASS;
                    else
                        state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (trial_sub[SPAN_BITS])
                    rem_next = trial[SPAN_BITS-1:0];
                else
                    rem_next = trial_sub[SPAN_BITS-1:0];
                shift_next = {shift_reg[TIME_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                    state_next = ST_BUCKET;
            end

            ST_BUCKET:
            begin
                bucket_next = cts_reg - {{(TIME_BITS-SPAN_BITS){1'b0}}, rem_reg};
                state_next  = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (bar_open_reg && (bucket_reg == bucket_start_reg))
                begin
                    if (ch_reg > acc_high_reg)
                        acc_high_next = ch_reg;
                    if (cl_reg < acc_low_reg)
                        acc_low_next = cl_reg;
                    acc_close_next  = cc_reg;
                    acc_volume_next = vol_sat;
                    state_next      = clast_reg ? ST_EMIT_FINAL : ST_IDLE;
                end
                else if (bar_open_reg)
                begin
                    state_next = ST_EMIT_OLD;
                end
                else
                begin
                    bar_open_next     = 1'b1;
                    bucket_start_next = bucket_reg;
                    acc_open_next     = co_reg;
                    acc_high_next     = ch_reg;
                    acc_low_next      = cl_reg;
                    acc_close_next    = cc_reg;
                    acc_volume_next   = cv_reg;
                    state_next        = clast_reg ? ST_EMIT_FINAL : ST_IDLE;
                end
            end

            ST_EMIT_OLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ts_next     = bucket_start_reg;
                    out_open_next   = acc_open_reg;
                    out_high_next   = acc_high_reg;
                    out_low_next    = acc_low_reg;
                    out_close_next  = acc_close_reg;
                    out_volume_next = acc_volume_reg;
                    out_final_next  = 1'b0;
                    if (pass_mode)
                    begin
                        bar_open_next     = 1'b0;
                        bucket_start_next = '0;
                        state_next        = ST_EMIT_PASS;
                    end
                    else
                    begin
                        bar_open_next     = 1'b1;
                        bucket_start_next = bucket_reg;
                        acc_open_next     = co_reg;
                        acc_high_next     = ch_reg;
                        acc_low_next      = cl_reg;
                        acc_close_next    = cc_reg;
                        acc_volume_next   = cv_reg;
                        state_next        = clast_reg ? ST_EMIT_FINAL : ST_IDLE;
                    end
                end
            end

            ST_EMIT_PASS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ts_next     = cts_reg;
                    out_open_next   = co_reg;
                    out_high_next   = ch_reg;
                    out_low_next    = cl_reg;
                    out_close_next  = cc_reg;
                    out_volume_next = cv_reg;
                    out_final_next  = clast_reg;
                    state_next      = ST_IDLE;
                end
            end

            ST_EMIT_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_ts_next       = bucket_start_reg;
                    out_open_next     = acc_open_reg;
                    out_high_next     = acc_high_reg;
                    out_low_next      = acc_low_reg;
                    out_close_next    = acc_close_reg;
                    out_volume_next   = acc_volume_reg;
                    out_final_next    = 1'b1;
                    bar_open_next     = 1'b0;
                    bucket_start_next = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            interval_reg     <= INTERVAL_RESET;
            span_reg         <= SPAN_BITS'(SECS_PER_MIN);
            cts_reg          <= '0;
            co_reg           <= '0;
            ch_reg           <= '0;
            cl_reg           <= '0;
            cc_reg           <= '0;
            cv_reg           <= '0;
            clast_reg        <= 1'b0;
            shift_reg        <= '0;
            rem_reg          <= '0;
            cnt_reg          <= '0;
            bucket_reg       <= '0;
            bar_open_reg     <= 1'b0;
            bucket_start_reg <= '0;
            acc_open_reg     <= '0;
            acc_high_reg     <= '0;
            acc_low_reg      <= '0;
            acc_close_reg    <= '0;
            acc_volume_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_ts_reg       <= '0;
            out_open_reg     <= '0;
            out_high_reg     <= '0;
            out_low_reg      <= '0;
            out_close_reg    <= '0;
            out_volume_reg   <= '0;
            out_final_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            interval_reg     <= interval_next;
            span_reg         <= span_next;
            cts_reg          <= cts_next;
            co_reg           <= co_next;
            ch_reg           <= ch_next;
            cl_reg           <= cl_next;
            cc_reg           <= cc_next;
            cv_reg           <= cv_next;
            clast_reg        <= clast_next;
            shift_reg        <= shift_next;
            rem_reg          <= rem_next;
            cnt_reg          <= cnt_next;
            bucket_reg       <= bucket_next;
            bar_open_reg     <= bar_open_next;
            bucket_start_reg <= bucket_start_next;
            acc_open_reg     <= acc_open_next;
            acc_high_reg     <= acc_high_next;
            acc_low_reg      <= acc_low_next;
            acc_close_reg    <= acc_close_next;
            acc_volume_reg   <= acc_volume_next;
            out_valid_reg    <= out_valid_next;
            out_ts_reg       <= out_ts_next;
            out_open_reg     <= out_open_next;
            out_high_reg     <= out_high_next;
            out_low_reg      <= out_low_next;
            out_close_reg    <= out_close_next;
            out_volume_reg   <= out_volume_next;
            out_final_reg    <= out_final_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bar_timestamp = out_ts_reg;
    assign bar_open      = out_open_reg;
    assign bar_high      = out_high_reg;
    assign bar_low       = out_low_reg;
    assign bar_close     = out_close_reg;
    assign bar_volume    = out_volume_reg;
    assign final_bar     = out_final_reg;

endmodule

/* tb/ohlcv_bar_aggregator_core_test.sv */
// ohlcv_bar_aggregator_core_test: checks candle resampling against an in-bench predictor
// of bar state, under directed and random candle histories, stalls and interval changes
// depends on ohlcv_pkg and ohlcv_bar_aggregator_core
module ohlcv_bar_aggregator_core_test;

    import ohlcv_pkg::*;

    localparam int TB = 40;
    localparam int VB = 48;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [TB-1:0] TS_MAX = '1;
    localparam logic [VB-1:0] VAL_MAX = '1;

    typedef struct {
        logic [TB-1:0] ts;
        logic [VB-1:0] op;
        logic [VB-1:0] hi;
        logic [VB-1:0] lo;
        logic [VB-1:0] cl;
        logic [VB-1:0] vol;
        logic          fin;
    } ohlcv_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [INTERVAL_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [TB-1:0]            candle_timestamp;
    logic [VB-1:0]            candle_open;
    logic [VB-1:0]            candle_high;
    logic [VB-1:0]            candle_low;
    logic [VB-1:0]            candle_close;
    logic [VB-1:0]            candle_volume;
    logic                     last_candle;
    logic                     out_valid;
    logic                     out_ready;
    logic [TB-1:0]            bar_timestamp;
    logic [VB-1:0]            bar_open;
    logic [VB-1:0]            bar_high;
    logic [VB-1:0]            bar_low;
    logic [VB-1:0]            bar_close;
    logic [VB-1:0]            bar_volume;
    logic                     final_bar;

    // predictor state
    logic [INTERVAL_BITS-1:0] interval_q;
    logic                     bar_live;
    ohlcv_t                   open_bar;

    ohlcv_t bars_due[$];
    ohlcv_t due_bar;
    int     errors;
    bit     steady;
    int     rx_hold;

    ohlcv_bar_aggregator_core #(
        .TIME_BITS(TB),
        .VALUE_BITS(VB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .candle_timestamp(candle_timestamp),
        .candle_open(candle_open),
        .candle_high(candle_high),
        .candle_low(candle_low),
        .candle_close(candle_close),
        .candle_volume(candle_volume),
        .last_candle(last_candle),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .bar_timestamp(bar_timestamp),
        .bar_open(bar_open),
        .bar_high(bar_high),
        .bar_low(bar_low),
        .bar_close(bar_close),
        .bar_volume(bar_volume),
        .final_bar(final_bar)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_bar();
        bar_live = 1'b0;
        open_bar = '{default: '0};
    endfunction

    function automatic void queue_bar(ohlcv_t b);
        bars_due.insert(bars_due.size(), b);
    endfunction

    function automatic void fold_candle(ohlcv_t c);
        longint unsigned span;
        longint unsigned bucket;
        logic [VB:0]     sum;
        if (interval_q <= 1)
        begin
            if (bar_live)
            begin
                queue_bar(open_bar);
                clear_bar();
            end
            queue_bar(c);
            if (c.fin)
                clear_bar();
        end
        else
        begin
            span = longint'(interval_q) * SECS_PER_MIN;
            bucket = longint'(c.ts) - (longint'(c.ts) % span);
            if (bar_live && bucket[TB-1:0] == open_bar.ts)
            begin
                if (c.hi > open_bar.hi)
                    open_bar.hi = c.hi;
                if (c.lo < open_bar.lo)
                    open_bar.lo = c.lo;
                open_bar.cl = c.cl;
                sum = {1'b0, open_bar.vol} + {1'b0, c.vol};
                open_bar.vol = sum[VB] ? VAL_MAX : sum[VB-1:0];
            end
            else
            begin
                if (bar_live)
                    queue_bar(open_bar);
                bar_live = 1'b1;
                open_bar = c;
                open_bar.ts = bucket[TB-1:0];
                open_bar.fin = 1'b0;
            end
            if (c.fin)
            begin
                open_bar.fin = 1'b1;
                queue_bar(open_bar);
                clear_bar();
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (steady || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VB-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return VAL_MAX;
            2: return VB'($urandom_range(0, 1000));
            3: return VAL_MAX - VB'($urandom_range(0, 100000));
            default: return VB'({$urandom, $urandom});
        endcase
    endfunction

    function automatic ohlcv_t rand_candle(logic [TB-1:0] ts, logic last);
        ohlcv_t c;
        c.ts = ts;
        c.op = rand_value();
        c.hi = rand_value();
        c.lo = rand_value();
        c.cl = rand_value();
        c.vol = rand_value();
        c.fin = last;
        return c;
    endfunction

    function automatic ohlcv_t mk(logic [TB-1:0] ts, logic [VB-1:0] o, logic [VB-1:0] h,
                                  logic [VB-1:0] l, logic [VB-1:0] c, logic [VB-1:0] v,
                                  logic last);
        ohlcv_t r;
        r = '{ts, o, h, l, c, v, last};
        return r;
    endfunction

    task automatic send_candle(ohlcv_t c);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        candle_timestamp = c.ts;
        candle_open = c.op;
        candle_high = c.hi;
        candle_low = c.lo;
        candle_close = c.cl;
        candle_volume = c.vol;
        last_candle = c.fin;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        fold_candle(c);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (bars_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_interval(logic [INTERVAL_BITS-1:0] minutes);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = minutes;
        @(negedge clk);
        cfg_we = 1'b0;
        interval_q = minutes;
    endtask

    // receiver side: random stalls plus long hold-offs on request
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else if (!steady && $urandom_range(0, 9) < 2)
            begin
                out_ready = 1'b0;
                stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            end
            else
                out_ready = 1'b1;
        end
    end

    function automatic void match(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bars_due.size() == 0)
            begin
                $error("bar word with none expected: bar_timestamp %0h", bar_timestamp);
                errors++;
            end
            else
            begin
                due_bar = bars_due.pop_front();
                match("bar_timestamp", due_bar.ts, bar_timestamp);
                match("bar_open", due_bar.op, bar_open);
                match("bar_high", due_bar.hi, bar_high);
                match("bar_low", due_bar.lo, bar_low);
                match("bar_close", due_bar.cl, bar_close);
                match("bar_volume", due_bar.vol, bar_volume);
                match("final_bar", due_bar.fin, final_bar);
            end
        end
    end

    task automatic test_passthrough();
        send_candle(mk('0, '0, '0, '0, '0, '0, 1'b0));
        send_candle(mk(TS_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 1'b1));
        send_candle(rand_candle(TB'(1_700_000_000), 1'b0));
        send_candle(rand_candle(TB'(1_700_000_060), 1'b1));
    endtask

    task automatic test_bar_merge();
        set_interval(5);
        send_candle(mk(TB'(300000), 100, 200, 50, 150, VAL_MAX - 10, 1'b0));
        send_candle(mk(TB'(300060), 7, 300, 40, 120, 100, 1'b0));
        send_candle(mk(TB'(300120), 9, 10, 60, 130, 5, 1'b0));
        send_candle(mk(TB'(300299), 11, 250, 45, 140, 0, 1'b1));
    endtask

    task automatic test_bucket_change();
        send_candle(rand_candle(TB'(600000), 1'b0));
        send_candle(rand_candle(TB'(600300), 1'b0));
        // timestamp going backwards opens another bar
        send_candle(rand_candle(TB'(599940), 1'b0));
        send_candle(rand_candle(TB'(599940), 1'b1));
        send_candle(rand_candle(TS_MAX, 1'b1));
    endtask

    task automatic test_interval_change_mid_bar();
        set_interval(3);
        send_candle(rand_candle(TB'(900000), 1'b0));
        send_candle(rand_candle(TB'(900060), 1'b0));
        // open bar leaves first when pass-through resumes
        set_interval(1);
        send_candle(rand_candle(TB'(900120), 1'b0));
    endtask

    task automatic test_interval_extremes();
        set_interval(0);
        send_candle(rand_candle(TB'(1234567), 1'b0));
        send_candle(rand_candle(TB'(1234627), 1'b1));
        set_interval(10080);
        send_candle(rand_candle(TB'(604800) * 3 - 60, 1'b0));
        send_candle(rand_candle(TB'(604800) * 3, 1'b1));
        set_interval('1);
        send_candle(rand_candle(TS_MAX - 60, 1'b0));
        send_candle(rand_candle('0, 1'b1));
    endtask

    task automatic test_backpressure();
        logic [TB-1:0] ts;
        set_interval(1);
        ts = TB'($urandom);
        rx_hold = 300;
        repeat (15)
        begin
            send_candle(rand_candle(ts, $urandom_range(0, 3) == 0));
            ts += 60;
        end
        // sender pauses until every bar word is back
        wait_drained();
    endtask

    task automatic test_random_histories(logic [INTERVAL_BITS-1:0] minutes, int items);
        logic [TB-1:0]   ts;
        int              sent;
        int              len;
        longint unsigned ival;
        set_interval(minutes);
        ival = (minutes == 0) ? 1 : minutes;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: ts = TB'({$urandom, $urandom});
                1: ts = TS_MAX - TB'($urandom_range(0, 100000));
                default: ts = TB'($urandom);
            endcase
            for (int k = 0; k < len; k++)
            begin
                send_candle(rand_candle(ts, k == len - 1 && $urandom_range(0, 7) != 0));
                sent++;
                case ($urandom_range(0, 15))
                    0: ts = ts;
                    1: ts -= TB'($urandom_range(1, 5000));
                    2: ts += TB'(60 * $urandom_range(0, 3 * ival + 1));
                    3: ts += TB'($urandom_range(1, 59));
                    default: ts += 60;
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        candle_timestamp = '0;
        candle_open = '0;
        candle_high = '0;
        candle_low = '0;
        candle_close = '0;
        candle_volume = '0;
        last_candle = 1'b0;
        errors = 0;
        steady = 1'b0;
        rx_hold = 0;
        interval_q = INTERVAL_RESET;
        clear_bar();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_passthrough();
        test_bar_merge();
        test_bucket_change();
        test_interval_change_mid_bar();
        test_interval_extremes();
        test_backpressure();

        test_random_histories(1, 90);
        test_random_histories(5, 90);
        steady = 1'b1;
        test_random_histories(2, 90);
        steady = 1'b0;
        test_random_histories(15, 90);
        test_random_histories(0, 90);
        test_random_histories(60, 90);
        steady = 1'b1;
        test_random_histories(1440, 90);
        steady = 1'b0;
        test_random_histories(10080, 90);
        test_random_histories('1, 90);
        test_random_histories(INTERVAL_BITS'($urandom_range(2, 10080)), 90);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
